// ===== hdl/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg: shared constants and types
// Width constants and the cell control types for the exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;
    localparam int WIDTH   = 64;
    localparam int CNT_W   = $clog2(WIDTH + 1);
    localparam int NCELLS  = 4;
    localparam int SLICE_W = WIDTH / NCELLS;

    // Control broadcast along the cell row for one multiply step.
    typedef struct packed {
        logic load;   // start a new product
        logic step;   // shift in one multiplier bit
        logic xbit;   // multiplier bit for this step
    } t_cell_ctrl;

    // Which candidate of the previous step becomes the partial remainder.
    typedef enum logic [1:0] {
        SEL_SUM  = 2'd0,   // 2r + x*y
        SEL_SUB1 = 2'd1,   // 2r + x*y - m
        SEL_SUB2 = 2'd2    // 2r + x*y - 2m
    } t_sel;
endpackage
`default_nettype wire

// ===== hdl/mexp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_in_if / mexp_out_if: item channels
// Valid/ready channels carrying the operand and result items.
// ----------------------------------------------------------------------------
interface mexp_in_if;
    import mexp_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] base_value;
    logic [WIDTH-1:0] exponent_value;
    logic [WIDTH-1:0] modulus_value;
    modport source (output valid, base_value, exponent_value, modulus_value, input ready);
    modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

interface mexp_out_if;
    import mexp_pkg::*;
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] power_result;
    logic             modulus_zero_error;
    modport source (output valid, power_result, modulus_zero_error, input ready);
    modport sink   (input valid, power_result, modulus_zero_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/mexp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_cell: one slice of the modular doubling/add datapath
// Holds SLICE_W bits of the three candidates of the partial remainder. Each
// step computes its slice of s = 2r + x*y, of s - m and of s - 2m, passing
// carries, borrows and shifted bits to the next cell; the row controller
// picks which candidate is the remainder for the next step.
// ----------------------------------------------------------------------------
module mexp_cell import mexp_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire t_sel               i_sel,
    input  wire logic [SLICE_W-1:0] i_y,
    input  wire logic [SLICE_W-1:0] i_m,
    input  wire logic               i_rmsb,      // top bit of previous slice of r
    input  wire logic               i_mmsb,      // top bit of previous slice of m
    input  wire logic               i_cin,
    input  wire logic               i_b1in,
    input  wire logic               i_b2in,
    output logic                    o_rmsb,
    output logic                    o_mmsb,
    output logic                    o_cout,
    output logic                    o_b1out,
    output logic                    o_b2out,
    output logic [SLICE_W-1:0]      o_r
);
    logic [SLICE_W-1:0] r_sum;
    logic [SLICE_W-1:0] r_sub1;
    logic [SLICE_W-1:0] r_sub2;
    logic [SLICE_W-1:0] n_r;
    logic [SLICE_W-1:0] w_m2;
    logic [SLICE_W:0]   w_sum;
    logic [SLICE_W:0]   w_sub1;
    logic [SLICE_W:0]   w_sub2;

    always_comb begin
        case (i_sel)
            SEL_SUB1: n_r = r_sub1;
            SEL_SUB2: n_r = r_sub2;
            default:  n_r = r_sum;
        endcase
        w_m2   = {i_m[SLICE_W-2:0], i_mmsb};
        w_sum  = {1'b0, n_r[SLICE_W-2:0], i_rmsb} + {1'b0, i_y & {SLICE_W{i_ctrl.xbit}}}
                 + {{SLICE_W{1'b0}}, i_cin};
        w_sub1 = {1'b0, w_sum[SLICE_W-1:0]} - {1'b0, i_m} - {{SLICE_W{1'b0}}, i_b1in};
        w_sub2 = {1'b0, w_sum[SLICE_W-1:0]} - {1'b0, w_m2} - {{SLICE_W{1'b0}}, i_b2in};
    end

    assign o_rmsb  = n_r[SLICE_W-1];
    assign o_mmsb  = i_m[SLICE_W-1];
    assign o_cout  = w_sum[SLICE_W];
    assign o_b1out = w_sub1[SLICE_W];
    assign o_b2out = w_sub2[SLICE_W];
    assign o_r     = n_r;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_sum  <= '0;
            r_sub1 <= '0;
            r_sub2 <= '0;
        end else if (i_ctrl.step) begin
            r_sum  <= w_sum[SLICE_W-1:0];
            r_sub1 <= w_sub1[SLICE_W-1:0];
            r_sub2 <= w_sub2[SLICE_W-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/mexp_row.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_row: modular multiplier built from a row of cells
// Computes x*y mod m MSB-first, one multiplier bit per cycle, with the
// carries and borrows rippling through the cells. Requires y < m. Done is
// high once the last multiplier bit is in, with the product on o_p.
// ----------------------------------------------------------------------------
module mexp_row import mexp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    input  wire logic [WIDTH-1:0] i_m,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_p
);
    logic [WIDTH-1:0] r_x;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    t_sel             r_sel;
    logic             r_fin;
    t_cell_ctrl       w_ctrl;
    logic [NCELLS:0]  w_c;
    logic [NCELLS:0]  w_b1;
    logic [NCELLS:0]  w_b2;
    logic [NCELLS:0]  w_msb;
    logic [NCELLS:0]  w_mm;
    logic [WIDTH-1:0] w_r;
    logic [1:0]       w_hi;
    logic [1:0]       w_need2;
    logic             w_ok1;
    logic             w_ok2;
    t_sel             w_selnext;

    assign w_ctrl.load = i_start;
    assign w_ctrl.step = r_busy;
    assign w_ctrl.xbit = r_x[WIDTH-1];
    assign w_c[0]   = 1'b0;
    assign w_b1[0]  = 1'b0;
    assign w_b2[0]  = 1'b0;
    assign w_msb[0] = 1'b0;
    assign w_mm[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NCELLS; g++) begin : g_cell
            mexp_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_sel  (r_sel),
                .i_y    (i_y[g*SLICE_W +: SLICE_W]),
                .i_m    (i_m[g*SLICE_W +: SLICE_W]),
                .i_rmsb (w_msb[g]),
                .i_mmsb (w_mm[g]),
                .i_cin  (w_c[g]),
                .i_b1in (w_b1[g]),
                .i_b2in (w_b2[g]),
                .o_rmsb (w_msb[g+1]),
                .o_mmsb (w_mm[g+1]),
                .o_cout (w_c[g+1]),
                .o_b1out(w_b1[g+1]),
                .o_b2out(w_b2[g+1]),
                .o_r    (w_r[g*SLICE_W +: SLICE_W])
            );
        end
    endgenerate

    // 2r + x*y < 3m: bits above WIDTH are the shifted-out r bit plus the carry.
    // Take the largest subtraction that leaves no net borrow.
    assign w_hi      = {1'b0, w_msb[NCELLS]} + {1'b0, w_c[NCELLS]};
    assign w_need2   = {1'b0, w_mm[NCELLS]} + {1'b0, w_b2[NCELLS]};
    assign w_ok2     = (w_hi >= w_need2);
    assign w_ok1     = (w_hi >= {1'b0, w_b1[NCELLS]});
    assign w_selnext = w_ok2 ? SEL_SUB2 : (w_ok1 ? SEL_SUB1 : SEL_SUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_sel  <= SEL_SUM;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_sel  <= SEL_SUM;
                r_cnt  <= CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_sel <= w_selnext;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
        end else if (r_busy) begin
            r_x <= {r_x[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done = r_fin;
    assign o_p    = w_r;
endmodule
`default_nettype wire

// ===== hdl/modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base^exponent mod modulus
// Right-to-left square-and-multiply around one bit-serial modular multiplier
// made of a row of cells.
//
//   channel | dir | fields
//   in      | in  | base_value, exponent_value, modulus_value
//   out     | out | power_result, modulus_zero_error
//
// One item at a time. Base reduction takes one product of the base by 1,
// then each exponent bit up to the highest set one costs a squaring plus a
// multiply when the bit is set. Zero modulus or zero exponent skips the
// multiplier: the item goes to the done state, then to the output register.
// Reset is synchronous; a stalled result holds in the output register
// while the next item may already be accepted.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit import mexp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mexp_in_if.sink   i_in,
    mexp_out_if.source o_out
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_acc;
    logic             r_err;
    logic             r_ovalid;
    logic [WIDTH-1:0] r_opow;
    logic             r_oerr;
    logic             r_go;
    logic [WIDTH-1:0] w_x;
    logic [WIDTH-1:0] w_y;
    logic             w_done;
    logic [WIDTH-1:0] w_p;
    logic             w_acc;
    logic             w_load_out;

    assign w_acc = i_in.valid & i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_load_out = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    always_comb begin
        unique case (r_state)
            S_RED:   begin w_x = r_b;   w_y = WIDTH'(1); end
            S_MUL:   begin w_x = r_acc; w_y = r_b;       end
            default: begin w_x = r_b;   w_y = r_b;       end
        endcase
    end

    mexp_row u_row (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go),
        .i_x    (w_x),
        .i_y    (w_y),
        .i_m    (r_m),
        .o_done (w_done),
        .o_p    (w_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_b   <= i_in.base_value;
                        r_e   <= i_in.exponent_value;
                        r_m   <= i_in.modulus_value;
                        r_err <= (i_in.modulus_value == '0);
                        r_acc <= (i_in.modulus_value == WIDTH'(1)
                                  && i_in.exponent_value != '0) ? '0 : WIDTH'(1);
                        if (i_in.modulus_value == '0 || i_in.exponent_value == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RED;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_RED: begin
                    if (w_done) begin
                        r_b <= w_p;
                        r_go <= 1'b1;
                        r_state <= r_e[0] ? S_MUL : S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_done) begin
                        r_acc <= w_p;
                        r_go <= 1'b1;
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (w_done) begin
                        r_b <= w_p;
                        r_e <= {1'b0, r_e[WIDTH-1:1]};
                        if (r_e[WIDTH-1:1] == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_go <= 1'b1;
                            r_state <= r_e[1] ? S_MUL : S_SQR;
                        end
                    end
                end
                S_DONE: begin
                    // hold until output register free
                    if (w_load_out) begin
                        r_opow   <= r_err ? '0 : r_acc;
                        r_oerr   <= r_err;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid              = r_ovalid;
    assign o_out.power_result       = r_opow;
    assign o_out.modulus_zero_error = r_oerr;
endmodule
`default_nettype wire

// ===== hdl/mexp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_checker: port-level checks
// Watches the item channels of the exponentiation unit.
// ----------------------------------------------------------------------------
module mexp_checker import mexp_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [WIDTH-1:0] i_pow,
    input wire logic             i_err
);
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err |-> i_pow == '0) else $error("error item with nonzero result");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pow))
        else $error("stalled result changed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("accepted while busy");
endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_pow      (o_out.power_result),
    .i_err      (o_out.modulus_zero_error)
);
`default_nettype wire

// ===== bench/modular_exponentiation_unit_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_checker: result prediction and comparison
// Watches both channels of the unit, computes base^exponent mod modulus by
// its own square-and-multiply for every accepted operand item, and compares
// each accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_checker import mexp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mexp_in_if        i_in,
    mexp_out_if       i_out,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen
);
    typedef struct {
        logic [WIDTH-1:0] power;
        logic             zero_err;
    } t_power_item;

    t_power_item power_queue[$];

    // (x * y) mod m at double width, exact
    function automatic logic [WIDTH-1:0] mulmod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
                                                logic [WIDTH-1:0] m);
        logic [2*WIDTH-1:0] prod;
        prod = {{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y};
        return WIDTH'(prod % {{WIDTH{1'b0}}, m});
    endfunction

    function automatic t_power_item predict_power(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e,
                                                  logic [WIDTH-1:0] m);
        t_power_item r;
        logic [WIDTH-1:0] acc;
        r.zero_err = 1'b0;
        acc = 1;
        if (m == 0) begin
            r.power = 0;
            r.zero_err = 1'b1;
            return r;
        end
        if (e != 0) begin
            b = b % m;
            acc = 1 % m;
            while (e != 0) begin
                if (e[0])
                    acc = mulmod(acc, b, m);
                b = mulmod(b, b, m);
                e = e >> 1;
            end
        end
        r.power = acc;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_power_item exp_item;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                power_queue = {power_queue, predict_power(i_in.base_value,
                                                          i_in.exponent_value,
                                                          i_in.modulus_value)};
            if (i_out.valid && i_out.ready) begin
                o_results_seen <= o_results_seen + 1;
                if (power_queue.size() == 0) begin
                    $error("unexpected result item: power_result %h", i_out.power_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = power_queue.pop_front();
                    if (i_out.power_result !== exp_item.power) begin
                        $error("power_result: expected %h, actual %h",
                               exp_item.power, i_out.power_result);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_out.modulus_zero_error !== exp_item.zero_err) begin
                        $error("modulus_zero_error: expected %b, actual %b",
                               exp_item.zero_err, i_out.modulus_zero_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= power_queue.size();
        end
    end
endmodule
`default_nettype wire

// ===== bench/modular_exponentiation_unit_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_tb: testbench top
// Drives directed and random operand items through the unit under four
// idling phases and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;
    import mexp_pkg::*;

    localparam int  CYCLE_LIMIT = 5_000_000;
    localparam int  N_RANDOM    = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    mexp_in_if  in_ch();
    mexp_out_if out_ch();

    modular_exponentiation_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    modular_exponentiation_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stalls at random
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [WIDTH-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // small operand sizes keep most items short
    function automatic logic [WIDTH-1:0] rand_sized(int max_bits);
        int nb;
        nb = $urandom_range(max_bits, 1);
        return rand_word() >> (WIDTH - nb);
    endfunction

    // valid stays high into the next item unless the sender idles
    task automatic send_item(logic [WIDTH-1:0] b, logic [WIDTH-1:0] e, logic [WIDTH-1:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.base_value     <= b;
        in_ch.exponent_value <= e;
        in_ch.modulus_value  <= m;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [WIDTH-1:0] b, e, m;
        int kind;
        kind = $urandom_range(9);
        b = (kind < 3) ? rand_word() : rand_sized(WIDTH);
        m = (kind == 0) ? rand_word() : rand_sized(WIDTH);
        if ($urandom_range(19) == 0)
            m = 0;
        // full-width exponents are slow; use them rarely
        e = (kind == 1) ? rand_word() : rand_sized(10);
        send_item(b, e, m);
    endtask

    initial begin
        logic [WIDTH-1:0] all1;
        all1 = '1;
        in_ch.valid = 1'b0;
        in_ch.base_value = '0;
        in_ch.exponent_value = '0;
        in_ch.modulus_value = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero modulus, zero exponent, modulus one, base above modulus, extremes
        send_item(5, 3, 0);
        send_item(all1, all1, 0);
        send_item(7, 0, 13);
        send_item(7, 0, 1);
        send_item(all1, 0, 0);
        send_item(7, 5, 1);
        send_item(100, 3, 7);
        send_item(all1, all1, all1);
        send_item(all1, 2, all1 - 1);
        send_item(2, 63, all1);
        send_item(0, 5, 97);
        send_item(0, 0, 97);
        send_item(all1 - 1, 1, all1);
        send_item(64'h8000_0000_0000_0000, all1, 64'hFFFF_FFFF_FFFF_FFC5);
        send_item(3, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
        send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAB);
        send_item(1, all1, 2);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 57 : (ph == 3) ? 34 : 0;
            recv_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 34 : 0;
            for (int i = 0; i < N_RANDOM / 4; i++)
                send_random();
        end
        in_ch.valid <= 1'b0;

        recv_stall_pct = 0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d operand items (directed and random) over four idling phases;",
                 items_sent);
        $display("checked %0d result items.", results_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
